FILE: rtl/srrip_set_replacement_assert.svh
// ----------------------------------------------------------------------------
// SRRIP set replacement assertion macros
// Shared property forms for the replacement state checks.
// ----------------------------------------------------------------------------
`ifndef SRRIP_SET_REPLACEMENT_ASSERT_SVH
`define SRRIP_SET_REPLACEMENT_ASSERT_SVH

// check a consequence in the same cycle
`define SRRIP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// check a consequence in the cycle after the antecedent
`define SRRIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/srrip_pkg.sv
// ----------------------------------------------------------------------------
// SRRIP package
// Action codes, controller states, cell control bundle and reset values.
// ----------------------------------------------------------------------------
package srrip_pkg;

  typedef enum logic [2:0] {
    ACT_AGE    = 3'd0,
    ACT_HIT    = 3'd1,
    ACT_FILL   = 3'd2,
    ACT_VICTIM = 3'd3,
    ACT_EVICT  = 3'd4,
    ACT_READ   = 3'd5
  } srrip_action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } srrip_state_e;

  typedef struct packed {
    logic age;
    logic wr;
    logic wr_valid;
    logic search;
  } srrip_cell_ctl_t;

  localparam logic [1:0] CFG_MAX_RRPV    = 2'd0;
  localparam logic [1:0] CFG_DENSE_RRPV  = 2'd1;
  localparam logic [1:0] CFG_ACTIVE_WAYS = 2'd2;

  localparam logic [3:0] MAX_RRPV_RST    = 4'd3;
  localparam logic [3:0] DENSE_RRPV_RST  = 4'd3;
  localparam logic [4:0] ACTIVE_WAYS_RST = 5'd16;

endpackage

FILE: rtl/srrip_cell.sv
// ----------------------------------------------------------------------------
// SRRIP way cell
// Holds one way's re-reference value and valid bit, applies aging and
// writes, and merges its way into the victim candidate passing through.
// ----------------------------------------------------------------------------
module srrip_cell import srrip_pkg::*; #(
  parameter int RRPV_BITS = 4,
  parameter int IDX_W     = 4,
  parameter int IDX       = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  srrip_cell_ctl_t      ctl_i,
  input  logic [3:0]           age_amt_i,
  input  logic [3:0]           max_rrpv_i,
  input  logic [RRPV_BITS-1:0] wr_val_i,
  input  logic                 scan_tok_i,
  input  logic                 scan_found_i,
  input  logic [IDX_W-1:0]     scan_idx_i,
  input  logic [RRPV_BITS-1:0] scan_val_i,
  output logic                 scan_tok_o,
  output logic                 scan_found_o,
  output logic [IDX_W-1:0]     scan_idx_o,
  output logic [RRPV_BITS-1:0] scan_val_o,
  output logic [RRPV_BITS-1:0] rrpv_o,
  output logic                 valid_o
);

  localparam int SumW = ((RRPV_BITS > 4) ? RRPV_BITS : 4) + 1;

  logic [RRPV_BITS-1:0] rrpv_q, rrpv_d;
  logic                 valid_q, valid_d;
  logic [SumW-1:0]      sum, max_ext, aged;
  logic                 take;
  logic                 tok_q;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [RRPV_BITS-1:0] val_q, val_d;

  always_comb begin
    sum     = SumW'(rrpv_q) + SumW'(age_amt_i);
    max_ext = SumW'(max_rrpv_i);
    if (!valid_q || (sum > max_ext)) begin
      aged = max_ext;
    end else begin
      aged = sum;
    end
  end

  always_comb begin
    rrpv_d  = rrpv_q;
    valid_d = valid_q;
    if (ctl_i.age) begin
      rrpv_d  = RRPV_BITS'(aged);
      valid_d = 1'b1;
    end else if (ctl_i.wr) begin
      rrpv_d  = wr_val_i;
      valid_d = ctl_i.wr_valid;
    end
  end

  always_comb begin
    take = ctl_i.search && valid_q && (!scan_found_i || (rrpv_q > scan_val_i));
    if (take) begin
      found_d = 1'b1;
      idx_d   = IDX_W'(IDX);
      val_d   = rrpv_q;
    end else begin
      found_d = scan_found_i;
      idx_d   = scan_idx_i;
      val_d   = scan_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rrpv_q  <= RRPV_BITS'(MAX_RRPV_RST);
      valid_q <= 1'b1;
      tok_q   <= 1'b0;
    end else begin
      rrpv_q  <= rrpv_d;
      valid_q <= valid_d;
      tok_q   <= scan_tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    idx_q   <= idx_d;
    val_q   <= val_d;
  end

  assign scan_tok_o   = tok_q;
  assign scan_found_o = found_q;
  assign scan_idx_o   = idx_q;
  assign scan_val_o   = val_q;
  assign rrpv_o       = rrpv_q;
  assign valid_o      = valid_q;

endmodule

FILE: rtl/srrip_set_replacement.sv
// ----------------------------------------------------------------------------
// SRRIP set replacement
// Re-reference state of one cache set with lazy aging, built as a row of
// way cells.
// ----------------------------------------------------------------------------
// Age, hit, fill, evict and read requests complete at the accept edge: the
// cells update in parallel and the result is registered at once. A victim
// request sends a token down the row of WAY_COUNT cells, one cell per cycle,
// each active, valid way folding into the running candidate; the result is
// registered from the done state. One request is in work at a time; the
// next is taken once the output register is free or being drained.
`include "srrip_set_replacement_assert.svh"

module srrip_set_replacement import srrip_pkg::*; #(
  parameter int WAY_COUNT = 16,
  parameter int RRPV_BITS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [4:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] action_i,
  input  logic [3:0] way_i,
  input  logic       from_ghost_i,
  input  logic       from_llc_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] victim_way_o,
  output logic       victim_found_o,
  output logic [3:0] counter_value_o,
  output logic       counter_valid_o
);

  localparam int IdxW = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int SumW = ((RRPV_BITS > 4) ? RRPV_BITS : 4) + 1;

  srrip_state_e  state_q, state_d;
  srrip_action_e act;

  logic [3:0] max_rrpv_q, dense_rrpv_q, pending_age_q;
  logic [4:0] active_ways_q;
  logic       pending_set_q;

  logic slot_free, go, launch, age_go, ld_direct, ld_victim;

  logic [WAY_COUNT-1:0] sel;
  logic [RRPV_BITS-1:0] wr_val;
  srrip_cell_ctl_t      ctl [WAY_COUNT];
  logic [RRPV_BITS-1:0] rrpv_w [WAY_COUNT];
  logic [WAY_COUNT-1:0] valid_w;

  logic [WAY_COUNT:0]   tok_c, found_c;
  logic [IdxW-1:0]      idx_c [WAY_COUNT+1];
  logic [RRPV_BITS-1:0] val_c [WAY_COUNT+1];

  logic                 fin_found_q;
  logic [IdxW-1:0]      fin_idx_q;
  logic [RRPV_BITS-1:0] fin_val_q;
  logic [SumW-1:0]      fin_ext, max_ext;
  logic [3:0]           age_gap;

  logic [3:0] rd_val;
  logic       rd_vld;

  logic       out_valid_q;
  logic [3:0] victim_way_q, counter_value_q;
  logic       victim_found_q, counter_valid_q;

  assign act = srrip_action_e'(action_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (launch) state_d = ST_SCAN;
      ST_SCAN: if (tok_c[WAY_COUNT]) state_d = ST_DONE;
      ST_DONE: if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    slot_free  = !out_valid_q || !out_stall_i;
    in_stall_o = !((state_q == ST_IDLE) && slot_free);
    go         = in_valid_i && !in_stall_o;
    launch     = go && (act == ACT_VICTIM);
    age_go     = go && (act == ACT_AGE) && pending_set_q;
    ld_direct  = go && (act != ACT_VICTIM);
    ld_victim  = (state_q == ST_DONE) && slot_free;
  end

  always_comb begin
    if ((act == ACT_FILL) && !from_ghost_i && !from_llc_i && (dense_rrpv_q != 4'd0)) begin
      wr_val = RRPV_BITS'(dense_rrpv_q - 4'd1);
    end else begin
      wr_val = '0;
    end
  end

  for (genvar i = 0; i < WAY_COUNT; i++) begin : g_cell
    assign sel[i]          = ({3'b000, way_i} == 7'(i));
    assign ctl[i].age      = age_go;
    assign ctl[i].wr       = go && sel[i] &&
                             ((act == ACT_HIT) || (act == ACT_FILL) || (act == ACT_EVICT));
    assign ctl[i].wr_valid = (act != ACT_EVICT);
    assign ctl[i].search   = (7'(i) < {2'b00, active_ways_q});

    srrip_cell #(
      .RRPV_BITS (RRPV_BITS),
      .IDX_W     (IdxW),
      .IDX       (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl[i]),
      .age_amt_i    (pending_age_q),
      .max_rrpv_i   (max_rrpv_q),
      .wr_val_i     (wr_val),
      .scan_tok_i   (tok_c[i]),
      .scan_found_i (found_c[i]),
      .scan_idx_i   (idx_c[i]),
      .scan_val_i   (val_c[i]),
      .scan_tok_o   (tok_c[i+1]),
      .scan_found_o (found_c[i+1]),
      .scan_idx_o   (idx_c[i+1]),
      .scan_val_o   (val_c[i+1]),
      .rrpv_o       (rrpv_w[i]),
      .valid_o      (valid_w[i])
    );
  end

  assign tok_c[0]   = launch;
  assign found_c[0] = 1'b0;
  assign idx_c[0]   = '0;
  assign val_c[0]   = '0;

  always_comb begin
    rd_val = '0;
    rd_vld = 1'b0;
    for (int i = 0; i < WAY_COUNT; i++) begin
      if (sel[i]) begin
        rd_val = 4'(rrpv_w[i]);
        rd_vld = valid_w[i];
      end
    end
  end

  always_comb begin
    fin_ext = SumW'(fin_val_q);
    max_ext = SumW'(max_rrpv_q);
    if (fin_ext < max_ext) begin
      age_gap = 4'(max_ext - fin_ext);
    end else begin
      age_gap = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      max_rrpv_q    <= MAX_RRPV_RST;
      dense_rrpv_q  <= DENSE_RRPV_RST;
      active_ways_q <= ACTIVE_WAYS_RST;
      pending_age_q <= 4'd0;
      pending_set_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_RRPV:    max_rrpv_q    <= cfg_wdata_i[3:0];
          CFG_DENSE_RRPV:  dense_rrpv_q  <= cfg_wdata_i[3:0];
          CFG_ACTIVE_WAYS: active_ways_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (age_go) begin
        pending_age_q <= 4'd0;
        pending_set_q <= 1'b0;
      end else if (ld_victim && fin_found_q) begin
        if (!pending_set_q || (age_gap < pending_age_q)) begin
          pending_age_q <= age_gap;
        end
        pending_set_q <= 1'b1;
      end
      if (ld_direct || ld_victim) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SCAN) && tok_c[WAY_COUNT]) begin
      fin_found_q <= found_c[WAY_COUNT];
      fin_idx_q   <= idx_c[WAY_COUNT];
      fin_val_q   <= val_c[WAY_COUNT];
    end
    if (ld_direct) begin
      victim_way_q    <= 4'd0;
      victim_found_q  <= 1'b0;
      counter_value_q <= ((act == ACT_READ) && rd_vld) ? rd_val : 4'd0;
      counter_valid_q <= (act == ACT_READ) && rd_vld;
    end else if (ld_victim) begin
      victim_way_q    <= fin_found_q ? 4'(fin_idx_q) : 4'd0;
      victim_found_q  <= fin_found_q;
      counter_value_q <= 4'd0;
      counter_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign victim_way_o    = victim_way_q;
  assign victim_found_o  = victim_found_q;
  assign counter_value_o = counter_value_q;
  assign counter_valid_o = counter_valid_q;

  `SRRIP_ASSERT_NEXT(a_victim_scans, launch, state_q == ST_SCAN, "victim request did not start a scan")
  `SRRIP_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok_c[WAY_COUNT:1]), "more than one scan token in the row")
  `SRRIP_ASSERT_NOW(a_pending_clear, $fell(pending_set_q), $past(age_go), "pending age dropped without an age request")

endmodule
